// ===== rtl/spq_pkg.sv =====
// Package for the sorted-insert priority queue.
// Holds sizes, error codes and the entry / cell control types.
// No dependencies.
`default_nettype none

package spq_pkg;

    localparam int DEPTH    = 16;
    localparam int KEY_BITS = 16;
    localparam int TAG_BITS = 16;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam int FILL_W   = 5;
    localparam int ERR_W    = 2;

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } t_entry;

    // Broadcast to every cell for one request.
    typedef struct packed {
        logic   push;
        logic   pop;
        t_entry item;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== rtl/spq_if.sv =====
// Request and result channel interfaces for the priority queue.
// Depends on spq_pkg for field widths.
`default_nettype none

interface spq_in_if;
    import spq_pkg::*;
    logic                valid;
    logic                ready;
    logic                mode;
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;

    modport source (output valid, output mode, output key, output tag, input ready);
    modport sink   (input valid, input mode, input key, input tag, output ready);
endinterface

interface spq_out_if;
    import spq_pkg::*;
    logic                valid;
    logic                ready;
    logic [KEY_BITS-1:0] head_key;
    logic [TAG_BITS-1:0] head_tag;
    logic                is_empty;
    logic [FILL_W-1:0]   fill_count;
    logic [ERR_W-1:0]    error_code;

    modport source (output valid, output head_key, output head_tag, output is_empty,
                    output fill_count, output error_code, input ready);
    modport sink   (input valid, input head_key, input head_tag, input is_empty,
                    input fill_count, input error_code, output ready);
endinterface

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// One slot of the sorted chain: holds an entry, shifts right on insert,
// left on pop. Depends on spq_pkg.
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_cell_ctl i_ctl,
    input  wire logic      i_occ,
    input  wire t_entry    i_left,
    input  wire logic      i_left_shift,
    input  wire t_entry    i_right,
    output t_entry         o_entry,
    output logic           o_shift
);

    t_entry r_entry;
    t_entry n_entry;

    // This entry moves right when the new key sorts before it.
    assign o_shift = i_occ && (r_entry.key > i_ctl.item.key);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.push) begin
            if (i_left_shift) begin
                n_entry = i_left;
            end else if (!i_occ || o_shift) begin
                n_entry = i_ctl.item;
            end
        end else if (i_ctl.pop) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

// ===== rtl/sorted_insert_priority_queue.sv =====
// Sorted-insert min priority queue built as a chain of shifting cells.
// The result of a request is registered and appears in the cycle after it is accepted.
// Throughput: one push or pop per cycle while the result side is ready; every cell compares and shifts at once.
// A new request is taken while the previous result is being taken.
// Reset empties the queue (count to zero); entry storage is not cleared.
`default_nettype none

module sorted_insert_priority_queue
    import spq_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    spq_in_if.sink     i_req,
    spq_out_if.source  o_res
);

    logic [CNT_BITS-1:0] r_count;
    logic [CNT_BITS-1:0] n_count;
    logic                r_out_valid;
    logic [ERR_W-1:0]    r_err;
    logic [ERR_W-1:0]    n_err;

    logic                accept;
    logic                is_full;
    logic                is_empty;
    t_cell_ctl           ctl;
    t_entry              w_entry [DEPTH];
    logic [DEPTH-1:0]    w_shift;
    logic [DEPTH-1:0]    w_occ;

    assign i_req.ready = !r_out_valid || o_res.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign is_full     = (r_count == CNT_BITS'(DEPTH));
    assign is_empty    = (r_count == '0);

    assign ctl.push     = accept && (i_req.mode == MODE_PUSH) && !is_full;
    assign ctl.pop      = accept && (i_req.mode == MODE_POP) && !is_empty;
    assign ctl.item.key = i_req.key;
    assign ctl.item.tag = i_req.tag;

    always_comb begin
        n_count = r_count;
        n_err   = r_err;
        if (accept) begin
            n_err = ERR_OK;
            if (i_req.mode == MODE_PUSH) begin
                if (is_full) begin
                    n_err = ERR_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end else begin
                if (is_empty) begin
                    n_err = ERR_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_entry left_e;
        t_entry right_e;
        logic   left_sh;

        assign w_occ[g] = (CNT_BITS'(g) < r_count);

        if (g == 0) begin : g_first
            assign left_e  = ctl.item;
            assign left_sh = 1'b0;
        end else begin : g_mid
            assign left_e  = w_entry[g-1];
            assign left_sh = w_shift[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_e = w_entry[g];
        end else begin : g_inner
            assign right_e = w_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_occ        (w_occ[g]),
            .i_left       (left_e),
            .i_left_shift (left_sh),
            .i_right      (right_e),
            .o_entry      (w_entry[g]),
            .o_shift      (w_shift[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_err       <= ERR_OK;
        end else begin
            r_count <= n_count;
            r_err   <= n_err;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // State only moves on accept, so the held result reads straight from the chain.
    assign o_res.valid      = r_out_valid;
    assign o_res.head_key   = is_empty ? '0 : w_entry[0].key;
    assign o_res.head_tag   = is_empty ? '0 : w_entry[0].tag;
    assign o_res.is_empty   = is_empty;
    assign o_res.fill_count = FILL_W'(r_count);
    assign o_res.error_code = r_err;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(DEPTH))
        else $error("entry count beyond depth");

    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_occ[1] |-> (w_entry[0].key <= w_entry[1].key))
        else $error("head pair out of order");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.push |=> (r_count == $past(r_count) + 1'b1) && (r_err == ERR_OK))
        else $error("push did not grow the queue");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req.mode == MODE_PUSH) && is_full) |=>
            (r_err == ERR_FULL) && $stable(r_count))
        else $error("push into full queue not dropped");

endmodule

`default_nettype wire
